/* rtl/core/met_pkg.sv */
package met_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 28;
  localparam int ITER_BITS  = 10;
  localparam int AREA_BITS  = 12;

  localparam int SIZE_BITS  = AREA_BITS + 1;
  localparam int SPAN_W     = COORD_BITS + 1;
  localparam int PROD_W     = SPAN_W + AREA_BITS + 1;
  localparam int MAG_W      = PROD_W - 1;
  localparam int SUM_W      = PROD_W + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int MAG_SQ_W   = SQ_W + 1;
  localparam int SAT_W      = (SUM_W > MAG_SQ_W) ? SUM_W : MAG_SQ_W;
  localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

  localparam int SHADE_BITS  = 8;
  localparam int SHADE_NUM_W = ITER_BITS + SHADE_BITS;
  localparam int SHADE_CNT_W = $clog2(SHADE_BITS);
  localparam int COLOR_W     = 32;
  localparam int RED_SHIFT   = 16;
  localparam logic [COLOR_W-1:0] COLOR_ALPHA = 32'hff00_0000;

  localparam logic [MAG_SQ_W-1:0] ESC_BOUND = MAG_SQ_W'(4) << (2 * FRAC_BITS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REAL_MIN   = 3'd0,
    CFG_REAL_MAX   = 3'd1,
    CFG_IMAG_MIN   = 3'd2,
    CFG_IMAG_MAX   = 3'd3,
    CFG_AREA_W     = 3'd4,
    CFG_AREA_H     = 3'd5,
    CFG_ITER_LIMIT = 3'd6
  } cfg_idx_e;

  // view defaults: -2.0 .. 1.0 by -1.5 .. 1.5
  localparam logic [COORD_BITS-1:0] RST_REAL_MIN = 32'he000_0000;
  localparam logic [COORD_BITS-1:0] RST_REAL_MAX = 32'h1000_0000;
  localparam logic [COORD_BITS-1:0] RST_IMAG_MIN = 32'he800_0000;
  localparam logic [COORD_BITS-1:0] RST_IMAG_MAX = 32'h1800_0000;
  localparam logic [SIZE_BITS-1:0]  RST_AREA_W   = SIZE_BITS'(300);
  localparam logic [SIZE_BITS-1:0]  RST_AREA_H   = SIZE_BITS'(200);
  localparam logic [ITER_BITS-1:0]  RST_LIMIT    = ITER_BITS'(30);

  localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) << (COORD_BITS - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] real_min;
    logic signed [COORD_BITS-1:0] real_max;
    logic signed [COORD_BITS-1:0] imag_min;
    logic signed [COORD_BITS-1:0] imag_max;
    logic [SIZE_BITS-1:0]         area_width;
    logic [SIZE_BITS-1:0]         area_height;
    logic [ITER_BITS-1:0]         iteration_limit;
  } met_cfg_t;

  typedef struct packed {
    logic [AREA_BITS-1:0]         col;
    logic [AREA_BITS-1:0]         row;
    logic signed [COORD_BITS-1:0] cr;
    logic signed [COORD_BITS-1:0] ci;
  } met_item_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [SAT_W-1:0] x
  );
    logic signed [COORD_BITS-1:0] res;
    if (x > SAT_HI) begin
      res = SAT_HI[COORD_BITS-1:0];
    end else if (x < SAT_LO) begin
      res = SAT_LO[COORD_BITS-1:0];
    end else begin
      res = x[COORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/mandelbrot_escape_time_pixel.sv */
// channel   direction  transfer when              payload
// cfg       in         cfg_we_i                   cfg_index_i, cfg_data_i
// pixel in  in         in_valid_i & in_ready_o    pixel_column_i, pixel_row_i
// pixel out out        out_valid_o & out_ready_i  column, row, count, shade, colour
//
// Mapping runs a multiply, then the two serial 45-bit dividers, per pixel.
// Iteration runs a multiply state and an update state per step, then the 8-step
// shade divide, which a point at the limit skips.
// Throughput is the slower of the two; a two-entry queue sits between them.
// Reset clears all control state and loads the default view; no clearing pass.
// One waiting result does not stop the next pixel from being mapped or iterated; a second one holds the iterator.
module mandelbrot_escape_time_pixel
  import met_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [AREA_BITS-1:0]  pixel_column_i,
  input  logic [AREA_BITS-1:0]  pixel_row_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [AREA_BITS-1:0]  out_column_o,
  output logic [AREA_BITS-1:0]  out_row_o,
  output logic [ITER_BITS-1:0]  iteration_count_o,
  output logic [SHADE_BITS-1:0] shade_o,
  output logic [COLOR_W-1:0]    pixel_color_o
);

  met_cfg_t  cfg_q;
  met_item_t push_item, pop_item;
  logic      push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_min        <= RST_REAL_MIN;
      cfg_q.real_max        <= RST_REAL_MAX;
      cfg_q.imag_min        <= RST_IMAG_MIN;
      cfg_q.imag_max        <= RST_IMAG_MAX;
      cfg_q.area_width      <= RST_AREA_W;
      cfg_q.area_height     <= RST_AREA_H;
      cfg_q.iteration_limit <= RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REAL_MIN:   cfg_q.real_min        <= cfg_data_i[COORD_BITS-1:0];
        CFG_REAL_MAX:   cfg_q.real_max        <= cfg_data_i[COORD_BITS-1:0];
        CFG_IMAG_MIN:   cfg_q.imag_min        <= cfg_data_i[COORD_BITS-1:0];
        CFG_IMAG_MAX:   cfg_q.imag_max        <= cfg_data_i[COORD_BITS-1:0];
        CFG_AREA_W:     cfg_q.area_width      <= cfg_data_i[SIZE_BITS-1:0];
        CFG_AREA_H:     cfg_q.area_height     <= cfg_data_i[SIZE_BITS-1:0];
        CFG_ITER_LIMIT: cfg_q.iteration_limit <= cfg_data_i[ITER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  met_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .push_o         (push),
    .item_o         (push_item),
    .full_i         (full)
  );

  met_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  met_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .limit_i           (cfg_q.iteration_limit),
    .item_i            (pop_item),
    .empty_i           (empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_column_o      (out_column_o),
    .out_row_o         (out_row_o),
    .iteration_count_o (iteration_count_o),
    .shade_o           (shade_o),
    .pixel_color_o     (pixel_color_o)
  );

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> iteration_count_o <= cfg_q.iteration_limit)
    else $error("iteration count beyond limit");

  a_inside_is_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && iteration_count_o == cfg_q.iteration_limit) |-> shade_o == '0)
    else $error("point at limit has non-zero shade");

  a_colour_packing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_color_o[23:16] == shade_o) && (pixel_color_o[7:0] == shade_o)
                    && (pixel_color_o[15:8] == 8'h00) && (pixel_color_o[31:24] == 8'hff))
    else $error("colour word does not match shade");

  a_queue_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

/* rtl/core/met_div.sv */
module met_div
  import met_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MAG_W-1:0]     num_i,
  input  logic [SIZE_BITS-1:0] den_i,
  output logic                 busy_o,
  output logic [MAG_W-1:0]     quot_o
);

  logic [MAG_W-1:0]     shift_q;
  logic [SIZE_BITS-1:0] rem_q;
  logic [SIZE_BITS-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SIZE_BITS:0]   trial;
  logic                 ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, shift_q[MAG_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(MAG_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= num_i;
      rem_q   <= '0;
      den_q   <= den_i;
    end else if (busy_o) begin
      shift_q <= {shift_q[MAG_W-2:0], ge};
      rem_q   <= ge ? SIZE_BITS'(trial - {1'b0, den_q}) : trial[SIZE_BITS-1:0];
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = shift_q;

endmodule

/* rtl/core/met_front.sv */
module met_front
  import met_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  met_cfg_t             cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [AREA_BITS-1:0] pixel_column_i,
  input  logic [AREA_BITS-1:0] pixel_row_i,
  output logic                 push_o,
  output met_item_t            item_o,
  input  logic                 full_i
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_LOAD = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [AREA_BITS-1:0]     col_q, row_q;
  logic signed [PROD_W-1:0] prod_re_q, prod_im_q;
  logic signed [SPAN_W-1:0] span_re, span_im;
  logic [MAG_W-1:0]         mag_re, mag_im;
  logic [MAG_W-1:0]         quot_re, quot_im;
  logic [SIZE_BITS-1:0]     den_re, den_im;
  logic                     busy_re, busy_im;
  logic                     div_start;
  logic signed [PROD_W-1:0] qs_re, qs_im;
  logic signed [PROD_W-1:0] neg_re, neg_im;

  assign span_re = SPAN_W'(cfg_i.real_max) - SPAN_W'(cfg_i.real_min);
  assign span_im = SPAN_W'(cfg_i.imag_max) - SPAN_W'(cfg_i.imag_min);

  assign den_re = (cfg_i.area_width  == '0) ? SIZE_BITS'(1) : cfg_i.area_width;
  assign den_im = (cfg_i.area_height == '0) ? SIZE_BITS'(1) : cfg_i.area_height;

  assign neg_re = -prod_re_q;
  assign neg_im = -prod_im_q;
  assign mag_re = prod_re_q[PROD_W-1] ? neg_re[MAG_W-1:0] : prod_re_q[MAG_W-1:0];
  assign mag_im = prod_im_q[PROD_W-1] ? neg_im[MAG_W-1:0] : prod_im_q[MAG_W-1:0];

  assign div_start  = state_q == F_LOAD;
  assign in_ready_o = state_q == F_IDLE;
  assign push_o     = (state_q == F_PUSH) && !full_i;

  met_div u_div_re (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag_re),
    .den_i   (den_re),
    .busy_o  (busy_re),
    .quot_o  (quot_re)
  );

  met_div u_div_im (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag_im),
    .den_i   (den_im),
    .busy_o  (busy_im),
    .quot_o  (quot_im)
  );

  // quotient truncates toward zero: sign applied after the magnitude divide
  always_comb begin
    qs_re = $signed({1'b0, quot_re});
    qs_im = $signed({1'b0, quot_im});
    if (prod_re_q[PROD_W-1]) begin
      qs_re = -qs_re;
    end
    if (prod_im_q[PROD_W-1]) begin
      qs_im = -qs_im;
    end
    item_o.col = col_q;
    item_o.row = row_q;
    item_o.cr  = sat_coord(SAT_W'(qs_re) + SAT_W'(cfg_i.real_min));
    item_o.ci  = sat_coord(SAT_W'(qs_im) + SAT_W'(cfg_i.imag_min));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = F_MUL;
        end
      end
      F_MUL:  state_d = F_LOAD;
      F_LOAD: state_d = F_DIV;
      F_DIV: begin
        if (!busy_re && !busy_im) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      col_q <= pixel_column_i;
      row_q <= pixel_row_i;
    end
    if (state_q == F_MUL) begin
      prod_re_q <= span_re * $signed({1'b0, col_q});
      prod_im_q <= span_im * $signed({1'b0, row_q});
    end
  end

endmodule

/* rtl/core/met_queue.sv */
module met_queue
  import met_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  met_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output met_item_t item_o,
  output logic      empty_o
);

  met_item_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
    logic [QUEUE_PTR_W-1:0] n;
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + QUEUE_PTR_W'(1);
    end
    return n;
  endfunction

  assign full_o  = cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QUEUE_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/met_back.sv */
module met_back
  import met_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ITER_BITS-1:0]  limit_i,
  input  met_item_t             item_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [AREA_BITS-1:0]  out_column_o,
  output logic [AREA_BITS-1:0]  out_row_o,
  output logic [ITER_BITS-1:0]  iteration_count_o,
  output logic [SHADE_BITS-1:0] shade_o,
  output logic [COLOR_W-1:0]    pixel_color_o
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_MUL   = 5'b00010,
    B_STEP  = 5'b00100,
    B_SHADE = 5'b01000,
    B_HOLD  = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [AREA_BITS-1:0]         col_q, row_q;
  logic signed [COORD_BITS-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [SQ_W-1:0]       rr_q, ii_q, ri_q;
  logic [ITER_BITS-1:0]         count_q;
  logic [SHADE_NUM_W-1:0]       rem_q, dsh_q;
  logic [SHADE_BITS-1:0]        sq_q;
  logic [SHADE_CNT_W-1:0]       sk_q;
  logic                         out_valid_q;

  logic [MAG_SQ_W-1:0]          mag;
  logic                         stop;
  logic signed [SQ_W-1:0]       diff, nr_sh, ri_sh;
  logic signed [COORD_BITS-1:0] zr_new, zi_new;
  logic                         sh_ge;
  logic                         load_out;

  assign mag    = {1'b0, rr_q} + {1'b0, ii_q};
  assign stop   = (mag > ESC_BOUND) || (count_q >= limit_i);
  assign diff   = rr_q - ii_q;
  assign nr_sh  = diff >>> FRAC_BITS;
  assign ri_sh  = ri_q >>> (FRAC_BITS - 1);
  assign zr_new = sat_coord(SAT_W'(nr_sh) + SAT_W'(cr_q));
  assign zi_new = sat_coord(SAT_W'(ri_sh) + SAT_W'(ci_q));

  assign sh_ge    = rem_q >= dsh_q;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign load_out = (state_q == B_HOLD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_MUL;
        end
      end
      B_MUL: state_d = B_STEP;
      B_STEP: begin
        if (!stop) begin
          state_d = B_MUL;
        end else if (count_q == limit_i) begin
          state_d = B_HOLD;
        end else begin
          state_d = B_SHADE;
        end
      end
      B_SHADE: begin
        if (sk_q == '0) begin
          state_d = B_HOLD;
        end
      end
      B_HOLD: begin
        if (load_out) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          col_q   <= item_i.col;
          row_q   <= item_i.row;
          cr_q    <= item_i.cr;
          ci_q    <= item_i.ci;
          zr_q    <= '0;
          zi_q    <= '0;
          count_q <= '0;
        end
      end
      B_MUL: begin
        rr_q <= zr_q * zr_q;
        ii_q <= zi_q * zi_q;
        ri_q <= zr_q * zi_q;
      end
      B_STEP: begin
        if (!stop) begin
          zr_q    <= zr_new;
          zi_q    <= zi_new;
          count_q <= count_q + ITER_BITS'(1);
        end else begin
          // 255*count, then one quotient bit a step from the top
          rem_q <= (SHADE_NUM_W'(count_q) << SHADE_BITS) - SHADE_NUM_W'(count_q);
          dsh_q <= SHADE_NUM_W'(limit_i) << (SHADE_BITS - 1);
          sk_q  <= SHADE_CNT_W'(SHADE_BITS - 1);
          sq_q  <= '0;
        end
      end
      B_SHADE: begin
        if (sh_ge) begin
          rem_q <= rem_q - dsh_q;
        end
        dsh_q <= dsh_q >> 1;
        sq_q  <= {sq_q[SHADE_BITS-2:0], sh_ge};
        sk_q  <= sk_q - SHADE_CNT_W'(1);
      end
      B_HOLD: begin
        if (load_out) begin
          out_column_o      <= col_q;
          out_row_o         <= row_q;
          iteration_count_o <= count_q;
          shade_o           <= sq_q;
          pixel_color_o     <= COLOR_ALPHA | (COLOR_W'(sq_q) << RED_SHIFT) | COLOR_W'(sq_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
